/* sv/msg_pkg.sv */
package msg_pkg;

	localparam int BW   = 18;
	localparam int NUMW = 17;
	localparam int DENW = 16;
	localparam int LVW  = 2;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [2:0] REG_FINE_SIZE   = 3'd0;
	localparam logic [2:0] REG_MID_SIZE    = 3'd1;
	localparam logic [2:0] REG_COARSE_SIZE = 3'd2;
	localparam logic [2:0] REG_WORLD_W     = 3'd3;
	localparam logic [2:0] REG_WORLD_H     = 3'd4;
	localparam logic [2:0] REG_CAPACITY    = 3'd5;

	typedef logic signed [BW-1:0] bound_t;

	typedef struct packed {
		bound_t x0;
		bound_t y0;
		bound_t x1;
		bound_t y1;
	} bnd_t;

	typedef struct packed {
		logic valid;
		bnd_t b;
	} bnd_word_t;

	typedef enum logic [2:0] {
		DIV_CW = 3'd0,
		DIV_CH = 3'd1,
		DIV_X0 = 3'd2,
		DIV_Y0 = 3'd3,
		DIV_X1 = 3'd4,
		DIV_Y1 = 3'd5
	} div_sel_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [7:0]         entity_id;
		logic [1:0]         grid_level;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [14:0]        box_width;
		logic [14:0]        box_height;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [10:0] cells_added;
		logic        needs_update;
	} rsp_t;

	typedef struct packed {
		logic     load;
		logic     lvl_from_req;
		logic     lvl_next;
		logic     load_size;
		logic     div_start;
		div_sel_t div_sel;
		logic     bnd_rd;
		logic     bnd_wr_ins;
		logic     bnd_wr_clr;
		logic     latch_sb;
		logic     walk_init;
		logic     walk_src_stored;
		logic     fill_rd;
		logic     ins_cell;
		logic     walk_step;
		logic     slot_init;
		logic     slot_rd;
		logic     slot_cmp;
		logic     fill_wr_k;
		logic     upd_cmp;
		logic     clr_step;
	} cmd_t;

	typedef struct packed {
		logic is_ins;
		logic is_rem;
		logic is_qry;
		logic neg;
		logic lvl_ok;
		logic lvl_last;
		logic div_done;
		logic sb_valid;
		logic walk_empty;
		logic walk_last;
		logic slot_end;
		logic clr_last;
		logic differ;
	} stat_t;

endpackage

/* sv/msg_ram.sv */
module msg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/msg_div.sv */
module msg_div import msg_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            done,
	output logic [NUMW-1:0] quo
);

	logic [NUMW-1:0] n_q;
	logic [DENW-1:0] rem_q;
	logic [4:0]      cnt_q;
	logic            done_q;
	logic [DENW:0]   trial;
	logic            ge;

	assign trial = {rem_q, n_q[NUMW-1]};
	assign ge    = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'(NUMW);
			end else if (cnt_q != 5'd0) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
		end else if (cnt_q != 5'd0) begin
			rem_q <= ge ? DENW'(trial - {1'b0, den}) : trial[DENW-1:0];
			n_q   <= {n_q[NUMW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

/* sv/msg_ctrl.sv */
module msg_ctrl import msg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	typedef enum logic [20:0] {
		S_CLEAR  = 21'd1,
		S_IDLE   = 21'd2,
		S_DISP   = 21'd4,
		S_BRD    = 21'd8,
		S_BLATCH = 21'd16,
		S_SIZE   = 21'd32,
		S_DGO    = 21'd64,
		S_DWAIT  = 21'd128,
		S_BWR    = 21'd256,
		S_WINIT  = 21'd512,
		S_WCHK   = 21'd1024,
		S_CRD    = 21'd2048,
		S_CINS   = 21'd4096,
		S_DFILL  = 21'd8192,
		S_SRD    = 21'd16384,
		S_SCMP   = 21'd32768,
		S_FWR    = 21'd65536,
		S_BCLR   = 21'd131072,
		S_CMP    = 21'd262144,
		S_NEXT   = 21'd524288,
		S_RESP   = 21'd1048576
	} state_t;

	state_t   state_q, state_d;
	div_sel_t div_q, div_d;
	div_sel_t div_last;

	assign div_last = st.is_rem ? DIV_CH : DIV_Y1;

	always_comb begin
		state_d = state_q;
		div_d   = div_q;
		cmd     = '0;
		cmd.div_sel = div_q;
		cmd.walk_src_stored = st.is_rem;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (st.is_ins) begin
					if (!st.neg && st.lvl_ok) begin
						cmd.lvl_from_req = 1'b1;
						state_d = S_SIZE;
					end else begin
						state_d = S_RESP;
					end
				end else if (st.is_rem || st.is_qry) begin
					state_d = S_BRD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_BRD: begin
				cmd.bnd_rd = 1'b1;
				state_d = S_BLATCH;
			end
			S_BLATCH: begin
				cmd.latch_sb = 1'b1;
				state_d = st.sb_valid ? S_SIZE : S_NEXT;
			end
			S_SIZE: begin
				cmd.load_size = 1'b1;
				div_d = st.is_qry ? DIV_X0 : DIV_CW;
				state_d = S_DGO;
			end
			S_DGO: begin
				cmd.div_start = 1'b1;
				state_d = S_DWAIT;
			end
			S_DWAIT: begin
				if (st.div_done) begin
					if (div_q == div_last) begin
						if (st.is_ins) begin
							state_d = S_BWR;
						end else if (st.is_rem) begin
							state_d = S_WINIT;
						end else begin
							state_d = S_CMP;
						end
					end else begin
						div_d = div_sel_t'(div_q + 3'd1);
						state_d = S_DGO;
					end
				end
			end
			S_BWR: begin
				cmd.bnd_wr_ins = 1'b1;
				state_d = S_WINIT;
			end
			S_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d = S_WCHK;
			end
			S_WCHK: begin
				if (st.walk_empty) begin
					state_d = st.is_ins ? S_RESP : S_BCLR;
				end else begin
					state_d = S_CRD;
				end
			end
			S_CRD: begin
				cmd.fill_rd = 1'b1;
				state_d = st.is_ins ? S_CINS : S_DFILL;
			end
			S_CINS: begin
				cmd.ins_cell  = 1'b1;
				cmd.walk_step = 1'b1;
				state_d = st.walk_last ? S_RESP : S_CRD;
			end
			S_DFILL: begin
				cmd.slot_init = 1'b1;
				state_d = S_SRD;
			end
			S_SRD: begin
				if (st.slot_end) begin
					state_d = S_FWR;
				end else begin
					cmd.slot_rd = 1'b1;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				cmd.slot_cmp = 1'b1;
				state_d = S_SRD;
			end
			S_FWR: begin
				cmd.fill_wr_k = 1'b1;
				cmd.walk_step = 1'b1;
				state_d = st.walk_last ? S_BCLR : S_CRD;
			end
			S_BCLR: begin
				cmd.bnd_wr_clr = 1'b1;
				state_d = S_NEXT;
			end
			S_CMP: begin
				cmd.upd_cmp = 1'b1;
				state_d = st.differ ? S_RESP : S_NEXT;
			end
			S_NEXT: begin
				if (st.lvl_last) begin
					state_d = S_RESP;
				end else begin
					cmd.lvl_next = 1'b1;
					state_d = S_BRD;
				end
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			div_q   <= DIV_CW;
		end else begin
			state_q <= state_d;
			div_q   <= div_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_RESP;

endmodule

/* sv/msg_dp.sv */
module msg_dp import msg_pkg::*; #(
	parameter int LEVELS             = 3,
	parameter int MAX_CELLS_PER_AXIS = 32,
	parameter int MAX_CAPACITY       = 8,
	parameter int ENTITY_COUNT       = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  cmd_t        cmd,
	output stat_t       st,
	output rsp_t        rsp
);

	localparam int M          = MAX_CELLS_PER_AXIS;
	localparam int MM         = M * M;
	localparam int CW         = $clog2(M);
	localparam int NCW        = $clog2(M + 1);
	localparam int FLW        = $clog2(MAX_CAPACITY + 1);
	localparam int EW         = $clog2(ENTITY_COUNT);
	localparam int FILL_DEPTH = LEVELS * MM;
	localparam int FAW        = $clog2(FILL_DEPTH);
	localparam int SLOT_DEPTH = FILL_DEPTH * MAX_CAPACITY;
	localparam int SAW        = $clog2(SLOT_DEPTH);
	localparam int BND_DEPTH  = ENTITY_COUNT * LEVELS;
	localparam int BAW        = $clog2(BND_DEPTH);
	localparam int CLR_DEPTH  = (FILL_DEPTH > BND_DEPTH) ? FILL_DEPTH : BND_DEPTH;
	localparam int CLW        = $clog2(CLR_DEPTH);
	localparam int WORDW      = 4 * BW + 1;

	logic [15:0] fine_q, mid_q, coarse_q, ww_q, wh_q;
	logic [3:0]  cap_cfg_q;
	logic [CLW-1:0] clr_q;

	req_t           req_q;
	logic [EW-1:0]  ent_q;
	logic [LVW-1:0] lvl_q;
	logic [15:0]    size_q;
	logic [NCW-1:0] nw_q, nh_q;
	bnd_t           b_q, sb_q;
	logic [CW-1:0]  x_q, y_q, xlo_q, xhi_q, yhi_q;
	logic           empty_q;
	logic [FLW-1:0] i_q, k_q;
	logic [10:0]    added_q;
	logic           upd_q;
	div_sel_t       dsel_q;
	logic           dneg_q;

	logic [FLW-1:0]  cap_v, fill_rdata, fill_wdata;
	logic            full, fill_we;
	logic [FAW-1:0]  cell_a, fill_waddr;
	logic [SAW-1:0]  slot_waddr, slot_raddr;
	logic [7:0]      slot_rdata, slot_wdata;
	logic            slot_we;
	logic [BAW-1:0]  bnd_a, bnd_waddr;
	bnd_word_t       bnd_rdata, bnd_wdata;
	logic            bnd_we;
	logic            clr_fill, clr_bnd;
	logic [15:0]     lvl_size;
	logic signed [18:0] nv;
	logic [18:0]     mag;
	logic            div_done;
	logic [NUMW-1:0] quo;
	bound_t          qval;
	bnd_t            src;
	bound_t          nwm1, nhm1, lox, loy, hix, hiy;
	logic            neg;
	logic [EW-1:0]   ent_tbl [256];

	for (genvar e = 0; e < 256; e++) begin : g_ent
		assign ent_tbl[e] = EW'(e % ENTITY_COUNT);
	end

	assign neg   = req_q.pos_x[15] | req_q.pos_y[15];
	assign cap_v = (int'(cap_cfg_q) > MAX_CAPACITY) ? FLW'(MAX_CAPACITY) : FLW'(cap_cfg_q);
	assign full  = fill_rdata >= cap_v;

	always_comb begin
		case (lvl_q)
			2'd0:    lvl_size = fine_q;
			2'd1:    lvl_size = mid_q;
			default: lvl_size = coarse_q;
		endcase
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_CW:  nv = $signed({3'b0, ww_q}) + $signed({3'b0, size_q}) - 19'sd1;
			DIV_CH:  nv = $signed({3'b0, wh_q}) + $signed({3'b0, size_q}) - 19'sd1;
			DIV_X0:  nv = {{3{req_q.pos_x[15]}}, req_q.pos_x};
			DIV_Y0:  nv = {{3{req_q.pos_y[15]}}, req_q.pos_y};
			DIV_X1:  nv = $signed({{3{req_q.pos_x[15]}}, req_q.pos_x})
				+ $signed({4'b0, req_q.box_width});
			DIV_Y1:  nv = $signed({{3{req_q.pos_y[15]}}, req_q.pos_y})
				+ $signed({4'b0, req_q.box_height});
			default: nv = '0;
		endcase
		mag = nv[18] ? 19'(-nv) : 19'(nv);
	end

	msg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (mag[NUMW-1:0]),
		.den    (size_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign qval = dneg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	always_comb begin
		src  = cmd.walk_src_stored ? sb_q : b_q;
		nwm1 = $signed({{(BW-NCW){1'b0}}, nw_q}) - 18'sd1;
		nhm1 = $signed({{(BW-NCW){1'b0}}, nh_q}) - 18'sd1;
		lox  = src.x0[BW-1] ? '0 : src.x0;
		loy  = src.y0[BW-1] ? '0 : src.y0;
		hix  = ($signed(src.x1) > $signed(nwm1)) ? nwm1 : src.x1;
		hiy  = ($signed(src.y1) > $signed(nhm1)) ? nhm1 : src.y1;
	end

	assign cell_a     = FAW'(int'(lvl_q) * MM + int'(y_q) * M + int'(x_q));
	assign bnd_a      = BAW'(int'(ent_q) * LEVELS + int'(lvl_q));
	assign clr_fill   = cmd.clr_step && (int'(clr_q) < FILL_DEPTH);
	assign clr_bnd    = cmd.clr_step && (int'(clr_q) < BND_DEPTH);

	assign fill_we    = clr_fill || (cmd.ins_cell && !full) || cmd.fill_wr_k;
	assign fill_waddr = cmd.clr_step ? clr_q[FAW-1:0] : cell_a;
	assign fill_wdata = cmd.clr_step ? '0 : (cmd.ins_cell ? fill_rdata + FLW'(1) : k_q);

	assign slot_we    = (cmd.ins_cell && !full) || (cmd.slot_cmp && slot_rdata != req_q.entity_id);
	assign slot_waddr = cmd.ins_cell ? SAW'(int'(cell_a) * MAX_CAPACITY + int'(fill_rdata))
		: SAW'(int'(cell_a) * MAX_CAPACITY + int'(k_q));
	assign slot_wdata = cmd.ins_cell ? req_q.entity_id : slot_rdata;
	assign slot_raddr = SAW'(int'(cell_a) * MAX_CAPACITY + int'(i_q));

	assign bnd_we     = clr_bnd || cmd.bnd_wr_ins || cmd.bnd_wr_clr;
	assign bnd_waddr  = cmd.clr_step ? clr_q[BAW-1:0] : bnd_a;
	assign bnd_wdata  = cmd.bnd_wr_ins ? {1'b1, b_q} : '0;

	msg_ram #(.WIDTH(FLW), .DEPTH(FILL_DEPTH)) u_fill (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (cmd.fill_rd),
		.raddr (cell_a),
		.rdata (fill_rdata)
	);

	msg_ram #(.WIDTH(8), .DEPTH(SLOT_DEPTH)) u_slot (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (cmd.slot_rd),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	msg_ram #(.WIDTH(WORDW), .DEPTH(BND_DEPTH)) u_bnd (
		.clk   (clk),
		.we    (bnd_we),
		.waddr (bnd_waddr),
		.wdata (bnd_wdata),
		.re    (cmd.bnd_rd),
		.raddr (bnd_a),
		.rdata (bnd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q    <= 16'd32;
			mid_q     <= 16'd64;
			coarse_q  <= 16'd128;
			ww_q      <= 16'd1024;
			wh_q      <= 16'd1024;
			cap_cfg_q <= 4'd8;
			clr_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FINE_SIZE:   fine_q    <= cfg_data;
					REG_MID_SIZE:    mid_q     <= cfg_data;
					REG_COARSE_SIZE: coarse_q  <= cfg_data;
					REG_WORLD_W:     ww_q      <= cfg_data;
					REG_WORLD_H:     wh_q      <= cfg_data;
					REG_CAPACITY:    cap_cfg_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + CLW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req;
			ent_q   <= ent_tbl[req.entity_id];
			lvl_q   <= '0;
			added_q <= '0;
			upd_q   <= 1'b0;
		end
		if (cmd.lvl_from_req) begin
			lvl_q <= req_q.grid_level;
		end
		if (cmd.lvl_next) begin
			lvl_q <= lvl_q + LVW'(1);
		end
		if (cmd.load_size) begin
			size_q <= (lvl_size == 16'd0) ? 16'd1 : lvl_size;
		end
		if (cmd.div_start) begin
			dsel_q <= cmd.div_sel;
			dneg_q <= nv[18];
		end
		if (div_done) begin
			case (dsel_q)
				DIV_CW:  nw_q <= (quo > NUMW'(M)) ? NCW'(M) : NCW'(quo);
				DIV_CH:  nh_q <= (quo > NUMW'(M)) ? NCW'(M) : NCW'(quo);
				DIV_X0:  b_q.x0 <= qval;
				DIV_Y0:  b_q.y0 <= qval;
				DIV_X1:  b_q.x1 <= qval;
				DIV_Y1:  b_q.y1 <= qval;
				default: ;
			endcase
		end
		if (cmd.latch_sb) begin
			sb_q <= bnd_rdata.b;
		end
		if (cmd.walk_init) begin
			x_q     <= lox[CW-1:0];
			xlo_q   <= lox[CW-1:0];
			xhi_q   <= hix[CW-1:0];
			y_q     <= loy[CW-1:0];
			yhi_q   <= hiy[CW-1:0];
			empty_q <= (nw_q == '0) || (nh_q == '0) || ($signed(lox) > $signed(hix))
				|| ($signed(loy) > $signed(hiy));
		end
		if (cmd.walk_step) begin
			if (x_q == xhi_q) begin
				x_q <= xlo_q;
				y_q <= y_q + CW'(1);
			end else begin
				x_q <= x_q + CW'(1);
			end
		end
		if (cmd.ins_cell && !full) begin
			added_q <= added_q + 11'd1;
		end
		if (cmd.slot_init) begin
			i_q <= '0;
			k_q <= '0;
		end
		if (cmd.slot_cmp) begin
			i_q <= i_q + FLW'(1);
			if (slot_rdata != req_q.entity_id) begin
				k_q <= k_q + FLW'(1);
			end
		end
		if (cmd.upd_cmp) begin
			upd_q <= b_q != sb_q;
		end
	end

	always_comb begin
		st.is_ins     = req_q.operation == OP_INSERT;
		st.is_rem     = req_q.operation == OP_REMOVE;
		st.is_qry     = req_q.operation == OP_QUERY;
		st.neg        = neg;
		st.lvl_ok     = {1'b0, req_q.grid_level} < 3'(LEVELS);
		st.lvl_last   = lvl_q == LVW'(LEVELS - 1);
		st.div_done   = div_done;
		st.sb_valid   = bnd_rdata.valid;
		st.walk_empty = empty_q;
		st.walk_last  = (x_q == xhi_q) && (y_q == yhi_q);
		st.slot_end   = i_q == fill_rdata;
		st.clr_last   = clr_q == CLW'(CLR_DEPTH - 1);
		st.differ     = b_q != sb_q;
	end

	assign rsp.status       = (req_q.operation == OP_INSERT) && neg;
	assign rsp.cells_added  = added_q;
	assign rsp.needs_update = upd_q;

endmodule

/* sv/multilevel_spatial_grid.sv */
// Multilevel spatial grid: insert, remove and query requests on a stack of uniform grids.
// A request is taken on start while busy is low; its result appears on rsp for exactly
// one cycle with done high, and the receiver cannot hold it off.
// Configuration is written through cfg_we, cfg_idx and cfg_data; the user must do so only
// while the block is idle, which the block does not enforce. One request is processed at
// a time, and one shared divider computes all quotients. An insert computes six quotients
// and visits each cell of its box. A remove computes, per placed level, two quotients
// and visits each cell of its stored box, reading each stored id. A query computes four
// quotients per placed level. Rejected, unknown and out-of-range requests go straight
// from dispatch to the response. After reset the block clears its cell fill counts and
// entity records, one entry per cycle, over the larger of LEVELS*MAX_CELLS_PER_AXIS**2
// and ENTITY_COUNT*LEVELS addresses (3072 by default); busy stays high during that pass.
// Cell contents are written before being read and are not cleared.
module multilevel_spatial_grid import msg_pkg::*; #(
	parameter int LEVELS             = 3,
	parameter int MAX_CELLS_PER_AXIS = 32,
	parameter int MAX_CAPACITY       = 8,
	parameter int ENTITY_COUNT       = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	cmd_t  cmd;
	stat_t st;

	msg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	msg_dp #(
		.LEVELS             (LEVELS),
		.MAX_CELLS_PER_AXIS (MAX_CELLS_PER_AXIS),
		.MAX_CAPACITY       (MAX_CAPACITY),
		.ENTITY_COUNT       (ENTITY_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.rsp      (rsp)
	);

endmodule
